FILE: sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key/value store package
// Beat types and fixed constants shared by the store's cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int CAP_WIDTH   = 5;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                          func;
        logic signed [FIELD_WIDTH-1:0] key;
        logic signed [FIELD_WIDTH-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic                          found;
        logic signed [FIELD_WIDTH-1:0] read_value;
        logic                          evicted;
        logic signed [FIELD_WIDTH-1:0] evicted_key;
    } out_beat_t;

    typedef struct packed {
        logic update;
        logic valid_next;
    } cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic first;
    } cell_stat_t;

endpackage

`default_nettype wire

FILE: sv/lru_key_value_store.sv
// ----------------------------------------------------------------------------
// LRU key/value store
// Result: an accepted input beat's result beat is registered and valid in the next cycle.
// Throughput: one beat per cycle; the whole chain of cells compares and
// shifts in the cycle of acceptance. The input stalls while a result beat waits.
// Reset: all entries invalid, count zero, capacity sixteen; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_store #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire lkv_pkg::in_beat_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lkv_pkg::out_beat_t                   out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lkv_pkg::CAP_WIDTH-1:0]   cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [lkv_pkg::CAP_WIDTH-1:0] capacity_reg;
    logic [lkv_pkg::CAP_WIDTH-1:0] capacity_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    lkv_pkg::out_beat_t            out_data_reg;
    lkv_pkg::out_beat_t            out_data_next;

    logic                          accept;
    logic                          is_put;
    logic                          hit_any;
    logic                          update;
    logic                          evict;
    logic [CW-1:0]                 cap_eff;
    logic [CW-1:0]                 count_left;
    logic [KEY_WIDTH-1:0]          lookup_key;
    logic [VALUE_WIDTH-1:0]        put_value;
    logic [VALUE_WIDTH-1:0]        hit_value;
    logic [KEY_WIDTH-1:0]          evict_key;
    logic [VALUE_WIDTH-1:0]        ins_value;
    logic [VALUE_WIDTH-1:0]        miss_value;

    logic                          chain [DEPTH+1];
    lkv_pkg::cell_stat_t           stat  [DEPTH];
    lkv_pkg::cell_ctrl_t           ctrl  [DEPTH];
    logic [KEY_WIDTH-1:0]          key_q [DEPTH];
    logic [VALUE_WIDTH-1:0]        value_q [DEPTH];
    logic                          last  [DEPTH];
    logic                          ev_sel [DEPTH];

    assign accept     = in_valid && !in_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign cfg_ready  = 1'b1;
    assign is_put     = (in_data.func == lkv_pkg::FUNC_PUT);
    assign lookup_key = KEY_WIDTH'($unsigned(in_data.key));
    assign put_value  = VALUE_WIDTH'($unsigned(in_data.value));
    assign miss_value = '1;
    assign ins_value  = is_put ? put_value : hit_value;

    assign chain[0]  = 1'b0;
    assign hit_any   = chain[DEPTH];
    assign update    = accept && (is_put || hit_any);

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [KEY_WIDTH-1:0]   prev_key;
            logic [VALUE_WIDTH-1:0] prev_value;

            if (i == 0)
            begin : g_head
                assign prev_key   = lookup_key;
                assign prev_value = ins_value;
            end
            else
            begin : g_body
                assign prev_key   = key_q[i-1];
                assign prev_value = value_q[i-1];
            end

            assign ctrl[i].update     = update;
            assign ctrl[i].valid_next = (CW'(i) < count_next);

            lkv_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[i]),
                .lookup_key (lookup_key),
                .prev_key   (prev_key),
                .prev_value (prev_value),
                .chain_in   (chain[i]),
                .chain_out  (chain[i+1]),
                .stat       (stat[i]),
                .key_q      (key_q[i]),
                .value_q    (value_q[i])
            );

            if (i == DEPTH - 1)
            begin : g_tail
                assign last[i]   = stat[i].valid;
                assign ev_sel[i] = stat[i].valid && !stat[i].hit && last[i];
            end
            else
            begin : g_mid
                assign last[i]   = stat[i].valid && !stat[i+1].valid;
                assign ev_sel[i] = stat[i].valid && !stat[i].hit &&
                                   (last[i] || (last[i+1] && stat[i+1].hit));
            end
        end
    endgenerate

    always_comb
    begin
        hit_value = '0;
        evict_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (stat[i].first)
            begin
                hit_value = hit_value | value_q[i];
            end
            if (ev_sel[i])
            begin
                evict_key = evict_key | key_q[i];
            end
        end
    end

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (int'(capacity_reg) > DEPTH)
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = CW'(capacity_reg);
        end
    end

    assign count_left = count_reg - CW'(hit_any);
    assign evict      = is_put && (count_left >= cap_eff);

    always_comb
    begin
        count_next = count_reg;
        if (accept && is_put)
        begin
            count_next = evict ? cap_eff : count_left + CW'(1);
        end
    end

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next            = 1'b1;
            out_data_next.found       = hit_any;
            out_data_next.evicted     = evict;
            out_data_next.evicted_key = evict ? lkv_pkg::FIELD_WIDTH'(evict_key) : '0;
            if (is_put)
            begin
                out_data_next.read_value = '0;
            end
            else if (hit_any)
            begin
                out_data_next.read_value = lkv_pkg::FIELD_WIDTH'(hit_value);
            end
            else
            begin
                out_data_next.read_value = lkv_pkg::FIELD_WIDTH'(miss_value);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= lkv_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: sv/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU store cell
// One slot of the recency chain: holds a key, a value and a valid bit,
// compares its key with the lookup key and takes its neighbour's entry
// when the chain shifts towards the least recent end.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lkv_pkg::cell_ctrl_t     ctrl,
    input  wire logic [KEY_WIDTH-1:0]    lookup_key,
    input  wire logic [KEY_WIDTH-1:0]    prev_key,
    input  wire logic [VALUE_WIDTH-1:0]  prev_value,
    input  wire logic                    chain_in,
    output logic                         chain_out,
    output lkv_pkg::cell_stat_t          stat,
    output logic [KEY_WIDTH-1:0]         key_q,
    output logic [VALUE_WIDTH-1:0]       value_q
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   hit;
    logic                   take;

    assign hit       = valid_reg && (key_reg == lookup_key);
    assign chain_out = chain_in | hit;
    assign take      = ctrl.update && !chain_in;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        if (take)
        begin
            key_next   = prev_key;
            value_next = prev_value;
        end
        if (ctrl.update)
        begin
            valid_next = ctrl.valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign stat.valid = valid_reg;
    assign stat.hit   = hit;
    assign stat.first = hit & !chain_in;
    assign key_q      = key_reg;
    assign value_q    = value_reg;

endmodule

`default_nettype wire

FILE: tb/sv/lru_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value store checker
// Watches the input, result and capacity channels of the store. It keeps its
// own recency-ordered copy of the entries and works out the result of every
// accepted input beat. Each accepted result beat is compared field by field
// with the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------

module lru_store_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  lkv_pkg::in_beat_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  lkv_pkg::out_beat_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lkv_pkg::CAP_WIDTH-1:0] cfg_data,
    output int                            mismatch_count,
    output int                            outstanding
);

    localparam int SLOTS = 16;

    logic [lkv_pkg::FIELD_WIDTH-1:0] chain_key   [SLOTS];
    logic [lkv_pkg::FIELD_WIDTH-1:0] chain_value [SLOTS];
    int                              chain_used;
    logic [lkv_pkg::CAP_WIDTH-1:0]   cap_setting;
    lkv_pkg::out_beat_t              pending_results [$];

    task automatic report_mismatch(input string what,
                                   input logic [lkv_pkg::FIELD_WIDTH-1:0] got,
                                   input logic [lkv_pkg::FIELD_WIDTH-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Slot 0 holds the most recent entry, slot chain_used-1 the least recent.
    task automatic predict_lru_access(input lkv_pkg::in_beat_t beat,
                                      output lkv_pkg::out_beat_t res);
        int                              idx;
        int                              limit;
        int                              i;
        bit                              hit;
        logic [lkv_pkg::FIELD_WIDTH-1:0] hv;
        res = '0;
        hit = 1'b0;
        idx = 0;
        for (i = 0; i < chain_used; i++)
        begin
            if (!hit && chain_key[i] == beat.key)
            begin
                hit = 1'b1;
                idx = i;
            end
        end
        if (beat.func == lkv_pkg::FUNC_GET)
        begin
            if (hit)
            begin
                hv = chain_value[idx];
                res.found = 1'b1;
                res.read_value = hv;
                for (i = idx; i > 0; i--)
                begin
                    chain_key[i] = chain_key[i-1];
                    chain_value[i] = chain_value[i-1];
                end
                chain_key[0] = beat.key;
                chain_value[0] = hv;
            end
            else
                res.read_value = '1;
        end
        else
        begin
            if (hit)
            begin
                res.found = 1'b1;
                for (i = idx; i < chain_used - 1; i++)
                begin
                    chain_key[i] = chain_key[i+1];
                    chain_value[i] = chain_value[i+1];
                end
                chain_used--;
            end
            limit = int'(cap_setting);
            if (limit == 0)
                limit = 1;
            if (limit > SLOTS)
                limit = SLOTS;
            // A lowered capacity drops everything from slot limit-1 onward.
            if (chain_used >= limit)
            begin
                res.evicted = 1'b1;
                res.evicted_key = chain_key[chain_used-1];
                chain_used = limit - 1;
            end
            for (i = chain_used; i > 0; i--)
            begin
                chain_key[i] = chain_key[i-1];
                chain_value[i] = chain_value[i-1];
            end
            chain_key[0] = beat.key;
            chain_value[0] = beat.value;
            chain_used++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin: watch
        lkv_pkg::out_beat_t predicted;
        lkv_pkg::out_beat_t want;
        if (!rst_n)
        begin
            chain_used = 0;
            cap_setting = lkv_pkg::CAP_RESET;
            pending_results.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_setting = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result beat with none expected", out_data.read_value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", lkv_pkg::FIELD_WIDTH'(out_data.found),
                                        lkv_pkg::FIELD_WIDTH'(want.found));
                    if (out_data.read_value !== want.read_value)
                        report_mismatch("read_value", out_data.read_value, want.read_value);
                    if (out_data.evicted !== want.evicted)
                        report_mismatch("evicted", lkv_pkg::FIELD_WIDTH'(out_data.evicted),
                                        lkv_pkg::FIELD_WIDTH'(want.evicted));
                    if (out_data.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", out_data.evicted_key, want.evicted_key);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_lru_access(in_data, predicted);
                pending_results.push_back(predicted);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/lru_key_value_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value store testbench
// Drives gets and puts into the store under a range of capacities, with
// random gaps on the input side and random stalls on the result side, one
// long result hold-off and one stretch with neither. Checking is left to the
// checker module, whose mismatch count decides the verdict.
// ----------------------------------------------------------------------------

module lru_key_value_store_tb;

    localparam int HOLD_CYCLES     = 150;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int POOL            = 20;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    lkv_pkg::in_beat_t               in_data;
    logic                            out_valid;
    logic                            out_stall;
    lkv_pkg::out_beat_t              out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lkv_pkg::CAP_WIDTH-1:0]   cfg_data;
    int                              mismatch_count;
    int                              outstanding;

    bit                              steady = 1'b0;
    bit                              hold_request = 1'b0;
    int                              hold_left;
    logic [lkv_pkg::FIELD_WIDTH-1:0] key_pool [POOL];

    lru_key_value_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lru_store_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // The result side: random stalls, or a long hold-off counted here.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !steady && ($urandom_range(0, 99) < 25);
        end
    end

    task automatic send_op(input logic func, input logic [lkv_pkg::FIELD_WIDTH-1:0] key,
                           input logic [lkv_pkg::FIELD_WIDTH-1:0] value);
        lkv_pkg::in_beat_t beat;
        beat.func = func;
        beat.key = key;
        beat.value = value;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_store;
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_WIDTH-1:0] cap);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                              phase;
        int                              n;
        int                              i;
        int                              cap_plan [PHASES];
        logic [lkv_pkg::FIELD_WIDTH-1:0] k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes of key and value, hits, misses and an update of a present key.
        send_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_op(lkv_pkg::FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_op(lkv_pkg::FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'hffff_ffff);
        send_op(lkv_pkg::FUNC_PUT, 32'hffff_ffff, 32'h0000_0000);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0001);
        send_op(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'hffff_ffff);
        send_op(lkv_pkg::FUNC_GET, 32'hffff_ffff, 32'h1234_5678);
        send_op(lkv_pkg::FUNC_GET, 32'h0000_002a, 32'h0000_0000);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_007b);
        drain_store;

        // Lowered capacity with five entries held: the next put trims.
        write_capacity(5'd2);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0063, 32'h5555_5555);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0063, 32'haaaa_aaaa);
        send_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_op(lkv_pkg::FUNC_GET, 32'h0000_0063, 32'h0000_0000);
        drain_store;

        // Capacity zero behaves as one.
        write_capacity(5'd0);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0050);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0060);
        send_op(lkv_pkg::FUNC_GET, 32'h0000_0006, 32'h0000_0000);
        drain_store;

        // Capacity above the depth behaves as the depth.
        write_capacity(5'd31);
        send_op(lkv_pkg::FUNC_PUT, 32'h0000_0007, 32'hdead_beef);
        send_op(lkv_pkg::FUNC_PUT, 32'hc000_0000, 32'h0000_0000);
        send_op(lkv_pkg::FUNC_GET, 32'h0000_0006, 32'h0000_0000);
        drain_store;

        cap_plan = '{31, 3, 0, 16, 1, 0, 16};
        cap_plan[5] = $urandom_range(0, 31);
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_capacity(lkv_pkg::CAP_WIDTH'(cap_plan[phase]));
            steady = (phase == 2);
            for (i = 0; i < POOL; i++)
                key_pool[i] = $urandom();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == 60)
                    hold_request = 1'b1;
                k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL - 1)]
                                                  : $urandom();
                send_op(($urandom_range(0, 99) < 55) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET,
                        k, $urandom());
            end
            drain_store;
            steady = 1'b0;
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_store.sv
tb/sv/lru_store_checker.sv
tb/sv/lru_key_value_store_tb.sv
